>>> hw/rtl/ogn_pkg.sv
// ogn_pkg: shared types, constants and request codes for the occupancy grid cull block
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package ogn_pkg;

  // grid geometry
  localparam int GRID_DIM_LOG2 = 4;
  localparam int GRID_DIM      = 1 << GRID_DIM_LOG2;
  localparam int CELL_W        = GRID_DIM_LOG2;
  localparam int ADDR_W        = 2 * CELL_W;
  localparam int CELLS         = GRID_DIM * GRID_DIM;
  localparam int COUNT_W       = 8;

  // request field widths
  localparam int REQ_W   = 3;
  localparam int RAD_W   = 3;
  localparam int WORLD_W = 16;

  localparam int MAX_RADIUS = 7;

  // command queue depth
  localparam int Q_DEPTH_LOG2 = 1;
  localparam int Q_DEPTH      = 1 << Q_DEPTH_LOG2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_MOVE   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 3'd4;

  // request beat
  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic [CELL_W-1:0]         cell_row;
    logic [CELL_W-1:0]         cell_col;
    logic signed [WORLD_W-1:0] world_x;
    logic signed [WORLD_W-1:0] world_z;
    logic                      update_map;
    logic [RAD_W-1:0]          radius;
  } req_t;

  // response beat
  typedef struct packed {
    logic              culled;
    logic [CELL_W-1:0] new_row;
    logic [CELL_W-1:0] new_col;
  } rsp_t;

  // work kinds the back end carries out
  typedef enum logic [2:0] {
    OP_ECHO,
    OP_CLEAR,
    OP_ADD,
    OP_REMOVE,
    OP_MOVE,
    OP_QUERY
  } op_t;

  // classified command passed from front to back
  typedef struct packed {
    op_t               op;
    logic [CELL_W-1:0] row;
    logic [CELL_W-1:0] col;
    logic [CELL_W-1:0] new_row;
    logic [CELL_W-1:0] new_col;
    logic [CELL_W-1:0] row_lo;
    logic [CELL_W-1:0] row_hi;
    logic [CELL_W-1:0] col_lo;
    logic [CELL_W-1:0] col_hi;
  } cmd_t;

endpackage

>>> hw/rtl/ogn_front.sv
// ogn_front: accepts request beats, holds the enable register and classifies requests
// depends on ogn_pkg
`timescale 1ns / 1ps

module ogn_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   grid_enable_we,
  input  logic                   grid_enable_wdata,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  ogn_pkg::req_t          req,
  output logic                   q_push,
  output ogn_pkg::cmd_t          q_cmd,
  input  logic                   q_full
);

  logic                            grid_enable;
  logic [ogn_pkg::WORLD_W-1:0]     x_off;
  logic [ogn_pkg::WORLD_W-1:0]     z_off;
  logic [ogn_pkg::CELL_W-1:0]      move_row;
  logic [ogn_pkg::CELL_W-1:0]      move_col;
  logic [ogn_pkg::RAD_W-1:0]       rad;
  logic [ogn_pkg::CELL_W:0]        row_sum;
  logic [ogn_pkg::CELL_W:0]        col_sum;
  logic [ogn_pkg::CELL_W-1:0]      rad_c;

  // enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_enable <= 1'b1;
    end else if (grid_enable_we) begin
      grid_enable <= grid_enable_wdata;
    end
  end

  // take a beat whenever the queue has room
  assign req_ready = !q_full;
  assign q_push    = req_valid && !q_full;

  // world position to cell: offset by half the range, keep the top bits
  assign x_off    = req.world_x ^ ogn_pkg::WORLD_W'(1 << (ogn_pkg::WORLD_W - 1));
  assign z_off    = req.world_z ^ ogn_pkg::WORLD_W'(1 << (ogn_pkg::WORLD_W - 1));
  assign move_row = x_off[ogn_pkg::WORLD_W-1 -: ogn_pkg::CELL_W];
  assign move_col = z_off[ogn_pkg::WORLD_W-1 -: ogn_pkg::CELL_W];

  // neighbourhood bounds, clipped to the grid
  assign rad     = (req.radius > ogn_pkg::RAD_W'(ogn_pkg::MAX_RADIUS)) ?
                   ogn_pkg::RAD_W'(ogn_pkg::MAX_RADIUS) : req.radius;
  assign rad_c   = ogn_pkg::CELL_W'(rad);
  assign row_sum = {1'b0, req.cell_row} + (ogn_pkg::CELL_W + 1)'(rad);
  assign col_sum = {1'b0, req.cell_col} + (ogn_pkg::CELL_W + 1)'(rad);

  // classify
  always_comb begin
    q_cmd.op      = ogn_pkg::OP_ECHO;
    q_cmd.row     = req.cell_row;
    q_cmd.col     = req.cell_col;
    q_cmd.new_row = req.cell_row;
    q_cmd.new_col = req.cell_col;
    q_cmd.row_lo  = (req.cell_row >= rad_c) ? req.cell_row - rad_c : '0;
    q_cmd.col_lo  = (req.cell_col >= rad_c) ? req.cell_col - rad_c : '0;
    q_cmd.row_hi  = row_sum[ogn_pkg::CELL_W] ? '1 : row_sum[ogn_pkg::CELL_W-1:0];
    q_cmd.col_hi  = col_sum[ogn_pkg::CELL_W] ? '1 : col_sum[ogn_pkg::CELL_W-1:0];
    unique case (req.req_type)
      ogn_pkg::REQ_CLEAR:  q_cmd.op = ogn_pkg::OP_CLEAR;
      ogn_pkg::REQ_ADD:    q_cmd.op = ogn_pkg::OP_ADD;
      ogn_pkg::REQ_REMOVE: q_cmd.op = ogn_pkg::OP_REMOVE;
      ogn_pkg::REQ_MOVE: begin
        if (grid_enable) begin
          q_cmd.new_row = move_row;
          q_cmd.new_col = move_col;
          if (req.update_map &&
              (move_row != req.cell_row || move_col != req.cell_col)) begin
            q_cmd.op = ogn_pkg::OP_MOVE;
          end
        end
      end
      ogn_pkg::REQ_QUERY: begin
        if (grid_enable) begin
          q_cmd.op = ogn_pkg::OP_QUERY;
        end
      end
      default: q_cmd.op = ogn_pkg::OP_ECHO;
    endcase
  end

endmodule

>>> hw/rtl/ogn_queue.sv
// ogn_queue: short command queue between the front and back ends
// depends on ogn_pkg
`timescale 1ns / 1ps

module ogn_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ogn_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output ogn_pkg::cmd_t pop_cmd,
  output logic          empty
);

  ogn_pkg::cmd_t                   slots [ogn_pkg::Q_DEPTH];
  logic [ogn_pkg::Q_DEPTH_LOG2-1:0] wr_ptr;
  logic [ogn_pkg::Q_DEPTH_LOG2-1:0] rd_ptr;
  logic [ogn_pkg::Q_DEPTH_LOG2:0]   count;

  assign full    = (count == (ogn_pkg::Q_DEPTH_LOG2 + 1)'(ogn_pkg::Q_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("command queue read while empty");
`endif

endmodule

>>> hw/rtl/ogn_back.sv
// ogn_back: carries out queued commands on the grid memory and drives the response register
// depends on ogn_pkg
`timescale 1ns / 1ps

module ogn_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  ogn_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ogn_pkg::rsp_t rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_SCAN,
    S_LAST
  } state_t;

  state_t                           state;
  ogn_pkg::cmd_t                    cmd;
  logic                             phase;
  logic                             hit;
  logic [ogn_pkg::CELL_W-1:0]       scan_r;
  logic [ogn_pkg::CELL_W-1:0]       scan_c;

  // grid memory with one valid bit per cell
  logic [ogn_pkg::COUNT_W-1:0]      mem [ogn_pkg::CELLS];
  logic [ogn_pkg::CELLS-1:0]        cell_vld;
  logic [ogn_pkg::COUNT_W-1:0]      rd_data;
  logic                             rd_vld;
  logic [ogn_pkg::COUNT_W-1:0]      count;

  logic                             rd_en;
  logic [ogn_pkg::ADDR_W-1:0]       rd_addr;
  logic                             wr_en;
  logic [ogn_pkg::ADDR_W-1:0]       wr_addr;
  logic [ogn_pkg::COUNT_W-1:0]      wr_data;
  logic                             clr_all;
  logic                             incr;

  logic                             rsp_free;
  logic                             start;
  logic                             echo_start;
  logic [ogn_pkg::CELL_W-1:0]       cur_r;
  logic [ogn_pkg::CELL_W-1:0]       cur_c;
  logic [ogn_pkg::CELL_W-1:0]       lo_c;
  logic [ogn_pkg::CELL_W-1:0]       hi_r;
  logic [ogn_pkg::CELL_W-1:0]       hi_c;
  logic [ogn_pkg::CELL_W-1:0]       nxt_r;
  logic [ogn_pkg::CELL_W-1:0]       nxt_c;
  logic                             scan_last;
  logic                             nonzero;

  assign rsp_free = !rsp_valid || rsp_ready;
  assign start    = (state == S_IDLE) && !q_empty && rsp_free;
  assign q_pop    = start;

  // commands answered straight from the queue head load the response this cycle
  assign echo_start = start && ((q_cmd.op == ogn_pkg::OP_ECHO) ||
                                (q_cmd.op == ogn_pkg::OP_CLEAR));

  // unwritten cells read as zero
  assign count   = rd_vld ? rd_data : '0;
  assign nonzero = (count != '0);

  // scan walker: first cell comes from the queue head, later ones from the counters
  always_comb begin
    if (state == S_IDLE) begin
      cur_r = q_cmd.row_lo;
      cur_c = q_cmd.col_lo;
      lo_c  = q_cmd.col_lo;
      hi_r  = q_cmd.row_hi;
      hi_c  = q_cmd.col_hi;
    end else begin
      cur_r = scan_r;
      cur_c = scan_c;
      lo_c  = cmd.col_lo;
      hi_r  = cmd.row_hi;
      hi_c  = cmd.col_hi;
    end
    scan_last = (cur_c == hi_c) && (cur_r == hi_r);
    nxt_c     = (cur_c == hi_c) ? lo_c : cur_c + 1'b1;
    nxt_r     = (cur_c == hi_c) ? cur_r + 1'b1 : cur_r;
  end

  // read-modify-write data path
  assign incr    = (cmd.op == ogn_pkg::OP_ADD) || ((cmd.op == ogn_pkg::OP_MOVE) && phase);
  assign wr_addr = phase ? {cmd.new_row, cmd.new_col} : {cmd.row, cmd.col};
  assign wr_data = incr ? ((count == '1) ? count : count + 1'b1)
                        : ((count == '0) ? count : count - 1'b1);

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {cur_r, cur_c};
    wr_en   = 1'b0;
    clr_all = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (q_cmd.op) inside
            ogn_pkg::OP_CLEAR: clr_all = 1'b1;
            ogn_pkg::OP_ADD, ogn_pkg::OP_REMOVE, ogn_pkg::OP_MOVE: begin
              rd_en   = 1'b1;
              rd_addr = {q_cmd.row, q_cmd.col};
            end
            ogn_pkg::OP_QUERY: rd_en = 1'b1;
            default: ;
          endcase
        end
      end
      S_WAIT: begin
        wr_en = 1'b1;
        if ((cmd.op == ogn_pkg::OP_MOVE) && !phase) begin
          rd_en   = 1'b1;
          rd_addr = {cmd.new_row, cmd.new_col};
        end
      end
      S_SCAN: rd_en = 1'b1;
      S_LAST: ;
      default: ;
    endcase
  end

  // grid storage
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // valid bits: reset and clear empty the whole grid at once
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_vld <= '0;
      rd_vld   <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld <= cell_vld[rd_addr];
      end
      if (clr_all) begin
        cell_vld <= '0;
      end else if (wr_en) begin
        cell_vld[wr_addr] <= 1'b1;
      end
    end
  end

  // sequencer and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && !echo_start) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd   <= q_cmd;
            phase <= 1'b0;
            hit   <= 1'b0;
            unique case (q_cmd.op) inside
              ogn_pkg::OP_ADD, ogn_pkg::OP_REMOVE, ogn_pkg::OP_MOVE: state <= S_WAIT;
              ogn_pkg::OP_QUERY: begin
                scan_r <= nxt_r;
                scan_c <= nxt_c;
                state  <= scan_last ? S_LAST : S_SCAN;
              end
              default: begin
                rsp_valid   <= 1'b1;
                rsp.culled  <= 1'b0;
                rsp.new_row <= q_cmd.new_row;
                rsp.new_col <= q_cmd.new_col;
              end
            endcase
          end
        end
        S_WAIT: begin
          if ((cmd.op == ogn_pkg::OP_MOVE) && !phase) begin
            phase <= 1'b1;
          end else begin
            rsp_valid   <= 1'b1;
            rsp.culled  <= 1'b0;
            rsp.new_row <= cmd.new_row;
            rsp.new_col <= cmd.new_col;
            state       <= S_IDLE;
          end
        end
        S_SCAN: begin
          hit    <= hit | nonzero;
          scan_r <= nxt_r;
          scan_c <= nxt_c;
          if (scan_last) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          rsp_valid   <= 1'b1;
          rsp.culled  <= !(hit | nonzero);
          rsp.new_row <= cmd.new_row;
          rsp.new_col <= cmd.new_col;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> $past(rd_en))
    else $error("grid write without a read in the previous cycle");
  a_scan_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_r >= cmd.row_lo && scan_r <= cmd.row_hi &&
                           scan_c >= cmd.col_lo && scan_c <= cmd.col_hi))
    else $error("neighbourhood scan left its bounds");
  a_move_distinct: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT && cmd.op == ogn_pkg::OP_MOVE) |->
      (cmd.row != cmd.new_row || cmd.col != cmd.new_col))
    else $error("count transfer between identical cells");
`endif

endmodule

>>> hw/rtl/occupancy_grid_neighbourhood_cull.sv
// Occupancy grid with neighbourhood cull: a 16x16 grid of saturating 8-bit counts held in one
// single-port-read grid memory, emptied at reset and by a clear request. Every request beat
// gives exactly one response beat, in order. Clear and requests touching no cell are answered
// from the queue head; add and remove read the cell, then write it in S_WAIT; a move that
// transfers a count does so for the old cell, then the new; a cull query reads each cell of
// the clipped square in turn and answers from S_LAST, its time set by the grid memory's one
// read per cycle. A two-entry command queue lets new requests be taken while the back end is
// busy or a response waits. With grid_enable low, queries answer not culled and moves return
// the cell given. The user must write grid_enable only while idle; the block does not enforce it.
// depends on ogn_pkg, ogn_front, ogn_queue, ogn_back
`timescale 1ns / 1ps

module occupancy_grid_neighbourhood_cull (
  input  logic          clk,
  input  logic          rst,
  input  logic          grid_enable_we,
  input  logic          grid_enable_wdata,
  input  logic          req_valid,
  output logic          req_ready,
  input  ogn_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ogn_pkg::rsp_t rsp
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  ogn_pkg::cmd_t push_cmd;
  ogn_pkg::cmd_t pop_cmd;

  // accept and classify
  ogn_front u_front (
    .clk               (clk),
    .rst               (rst),
    .grid_enable_we    (grid_enable_we),
    .grid_enable_wdata (grid_enable_wdata),
    .req_valid         (req_valid),
    .req_ready         (req_ready),
    .req               (req),
    .q_push            (q_push),
    .q_cmd             (push_cmd),
    .q_full            (q_full)
  );

  // decoupling queue
  ogn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  // grid work and response
  ogn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

>>> tb/sv/tb_occupancy_grid_neighbourhood_cull.sv
// tb_occupancy_grid_neighbourhood_cull: self-checking bench for the occupancy grid cull block
// keeps its own copy of the grid and the enable bit, predicts one answer per request beat
// depends on ogn_pkg and occupancy_grid_neighbourhood_cull
`timescale 1ns / 1ps

module tb_occupancy_grid_neighbourhood_cull;

  typedef logic [ogn_pkg::CELL_W-1:0]         cell_idx_t;
  typedef logic [ogn_pkg::REQ_W-1:0]          req_code_t;
  typedef logic [ogn_pkg::RAD_W-1:0]          radius_t;
  typedef logic signed [ogn_pkg::WORLD_W-1:0] world_t;

  // request kinds the block leaves alone
  localparam req_code_t REQ_UNDEF_FIRST = 3'd5;
  localparam req_code_t REQ_UNDEF_LAST  = 3'd7;

  localparam int MAX_GAP        = 12;
  localparam int REPORT_LIMIT   = 10;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 300;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_ITEMS    = 40;
  localparam int TRACKED_MAX    = 48;

  typedef struct packed {
    cell_idx_t row;
    cell_idx_t col;
  } cell_t;

  logic           clk;
  logic           rst;
  logic           grid_enable_we;
  logic           grid_enable_wdata;
  logic           req_valid;
  logic           req_ready;
  ogn_pkg::req_t  req;
  logic           rsp_valid;
  logic           rsp_ready;
  ogn_pkg::rsp_t  rsp;

  // shadow of the grid and the enable register
  logic [ogn_pkg::COUNT_W-1:0] grid_counts [ogn_pkg::CELLS];
  bit                          grid_on;

  ogn_pkg::rsp_t expected_answers [$];
  cell_t         tracked_cells [$];
  int            mismatch_count;
  int            rx_stall;
  bit            tx_burst;
  bit            rx_burst;

  occupancy_grid_neighbourhood_cull dut (
    .clk               (clk),
    .rst               (rst),
    .grid_enable_we    (grid_enable_we),
    .grid_enable_wdata (grid_enable_wdata),
    .req_valid         (req_valid),
    .req_ready         (req_ready),
    .req               (req),
    .rsp_valid         (rsp_valid),
    .rsp_ready         (rsp_ready),
    .rsp               (rsp)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("tb_occupancy_grid_neighbourhood_cull: errors");
    $finish;
  end

  // saturating count helpers
  function automatic void bump_cell(cell_idx_t row, cell_idx_t col);
    if (grid_counts[{row, col}] != '1) grid_counts[{row, col}]++;
  endfunction

  function automatic void drop_cell(cell_idx_t row, cell_idx_t col);
    if (grid_counts[{row, col}] != '0) grid_counts[{row, col}]--;
  endfunction

  // world coordinate to cell: top bits with the sign flipped
  function automatic cell_idx_t world_cell(world_t w);
    return {~w[ogn_pkg::WORLD_W-1], w[ogn_pkg::WORLD_W-2 -: ogn_pkg::CELL_W-1]};
  endfunction

  // any world coordinate that lands in the given cell
  function automatic world_t world_for_cell(cell_idx_t c);
    logic [31:0] raw;
    raw = $urandom;
    return {~c[ogn_pkg::CELL_W-1], c[ogn_pkg::CELL_W-2:0],
            raw[ogn_pkg::WORLD_W-ogn_pkg::CELL_W-1:0]};
  endfunction

  // apply one request to the shadow grid and work out its answer
  function automatic ogn_pkg::rsp_t predict_grid(ogn_pkg::req_t r);
    ogn_pkg::rsp_t o;
    int            rad;
    int            rr;
    int            cc;
    cell_idx_t     nr;
    cell_idx_t     nc;
    o.culled  = 1'b0;
    o.new_row = r.cell_row;
    o.new_col = r.cell_col;
    case (r.req_type)
      ogn_pkg::REQ_CLEAR: begin
        foreach (grid_counts[i]) grid_counts[i] = '0;
      end
      ogn_pkg::REQ_ADD: begin
        bump_cell(r.cell_row, r.cell_col);
      end
      ogn_pkg::REQ_REMOVE: begin
        drop_cell(r.cell_row, r.cell_col);
      end
      ogn_pkg::REQ_MOVE: begin
        if (grid_on) begin
          nr = world_cell(r.world_x);
          nc = world_cell(r.world_z);
          o.new_row = nr;
          o.new_col = nc;
          if (r.update_map && {nr, nc} != {r.cell_row, r.cell_col}) begin
            drop_cell(r.cell_row, r.cell_col);
            bump_cell(nr, nc);
          end
        end
      end
      ogn_pkg::REQ_QUERY: begin
        if (grid_on) begin
          rad = (r.radius > ogn_pkg::MAX_RADIUS) ? ogn_pkg::MAX_RADIUS : int'(r.radius);
          o.culled = 1'b1;
          for (rr = int'(r.cell_row) - rad; rr <= int'(r.cell_row) + rad; rr++)
            for (cc = int'(r.cell_col) - rad; cc <= int'(r.cell_col) + rad; cc++)
              if (rr >= 0 && rr < ogn_pkg::GRID_DIM && cc >= 0 && cc < ogn_pkg::GRID_DIM &&
                  grid_counts[rr * ogn_pkg::GRID_DIM + cc] != '0)
                o.culled = 1'b0;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // request of a given kind, every other field random
  function automatic ogn_pkg::req_t random_req(req_code_t kind, cell_idx_t row,
                                               cell_idx_t col);
    ogn_pkg::req_t r;
    r.req_type   = kind;
    r.cell_row   = row;
    r.cell_col   = col;
    r.world_x    = world_t'($urandom);
    r.world_z    = world_t'($urandom);
    r.update_map = ($urandom_range(0, 1) != 0);
    r.radius     = radius_t'($urandom);
    return r;
  endfunction

  // send one request beat; valid stays up after acceptance until the next gap
  task automatic send_request(input ogn_pkg::req_t r, output ogn_pkg::rsp_t want);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    want = predict_grid(r);
    expected_answers.push_back(want);
  endtask

  task automatic send_kind(req_code_t kind, cell_idx_t row, cell_idx_t col);
    ogn_pkg::rsp_t want;
    send_request(random_req(kind, row, col), want);
  endtask

  task automatic send_query(cell_idx_t row, cell_idx_t col, radius_t rad);
    ogn_pkg::req_t r;
    ogn_pkg::rsp_t want;
    r = random_req(ogn_pkg::REQ_QUERY, row, col);
    r.radius = rad;
    send_request(r, want);
  endtask

  task automatic send_move(cell_idx_t row, cell_idx_t col, world_t wx, world_t wz,
                           logic upd);
    ogn_pkg::req_t r;
    ogn_pkg::rsp_t want;
    r = random_req(ogn_pkg::REQ_MOVE, row, col);
    r.world_x    = wx;
    r.world_z    = wz;
    r.update_map = upd;
    send_request(r, want);
  endtask

  // drop valid and wait until every answer is back
  task automatic drain_grid();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_grid_enable(bit v);
    drain_grid();
    @(negedge clk);
    grid_enable_we    <= 1'b1;
    grid_enable_wdata <= v;
    @(negedge clk);
    grid_enable_we    <= 1'b0;
    grid_on = v;
  endtask

  // corners, edge clipping and the radius range, starting from the reset state
  task automatic test_corners_and_radius();
    send_query(0, 0, 0);
    send_query(15, 15, 7);
    send_kind(ogn_pkg::REQ_ADD, 0, 0);
    send_kind(ogn_pkg::REQ_ADD, 15, 15);
    send_kind(ogn_pkg::REQ_ADD, 0, 15);
    send_kind(ogn_pkg::REQ_ADD, 15, 0);
    send_query(8, 8, 7);
    send_query(7, 7, 7);
    send_query(3, 12, 3);
    send_query(8, 8, 0);
    send_query(2, 2, 1);
    send_query(14, 14, 1);
    send_query(13, 13, 1);
  endtask

  // remove stops at zero
  task automatic test_remove_floor();
    send_kind(ogn_pkg::REQ_REMOVE, 0, 0);
    send_kind(ogn_pkg::REQ_REMOVE, 0, 0);
    send_query(1, 1, 1);
    send_kind(ogn_pkg::REQ_REMOVE, 5, 5);
    send_query(5, 5, 0);
  endtask

  // world extremes, same-cell move, no-update move, transfer from an empty cell
  task automatic test_move();
    send_move(15, 15, 16'sh8000, 16'sh7fff, 1'b1);
    send_query(15, 15, 0);
    send_move(0, 15, world_for_cell(0), world_for_cell(15), 1'b1);
    send_move(0, 15, 16'sh0000, 16'shffff, 1'b0);
    send_move(3, 3, 16'sh0000, 16'sh0000, 1'b1);
    send_query(8, 8, 0);
    send_move(8, 8, 16'shffff, 16'sh0000, 1'b1);
    send_query(7, 8, 0);
    send_query(3, 3, 0);
  endtask

  // count saturates at the top, on add and on a transfer in
  task automatic test_saturation();
    tx_burst = 1'b1;
    repeat (256) send_kind(ogn_pkg::REQ_ADD, 5, 9);
    send_kind(ogn_pkg::REQ_ADD, 6, 9);
    send_move(6, 9, world_for_cell(5), world_for_cell(9), 1'b1);
    send_query(6, 9, 0);
    send_query(5, 9, 0);
    send_kind(ogn_pkg::REQ_REMOVE, 5, 9);
    send_query(5, 9, 0);
    send_kind(ogn_pkg::REQ_CLEAR, 0, 0);
    send_query(5, 9, 0);
    tx_burst = 1'b0;
  endtask

  // grid disabled: never culled, move echoes, add/remove/clear still act
  task automatic test_disabled();
    set_grid_enable(1'b0);
    send_kind(ogn_pkg::REQ_CLEAR, cell_idx_t'($urandom), cell_idx_t'($urandom));
    send_query(8, 8, 7);
    send_move(2, 3, world_for_cell(11), world_for_cell(4), 1'b1);
    send_kind(ogn_pkg::REQ_ADD, 4, 4);
    send_kind(ogn_pkg::REQ_REMOVE, 4, 4);
    send_kind(ogn_pkg::REQ_ADD, 4, 4);
    set_grid_enable(1'b1);
    send_query(4, 4, 0);
    send_query(2, 3, 0);
    set_grid_enable(1'b0);
    send_kind(ogn_pkg::REQ_CLEAR, cell_idx_t'($urandom), cell_idx_t'($urandom));
    set_grid_enable(1'b1);
    send_query(4, 4, 0);
  endtask

  // unused kinds are ignored and echo the cell
  task automatic test_undefined();
    int k;
    send_kind(ogn_pkg::REQ_ADD, 10, 10);
    for (k = int'(REQ_UNDEF_FIRST); k <= int'(REQ_UNDEF_LAST); k++)
      send_kind(req_code_t'(k), cell_idx_t'($urandom), cell_idx_t'($urandom));
    send_query(10, 10, 0);
  endtask

  // one random request, often about cells that hold an object
  task automatic random_item();
    ogn_pkg::req_t r;
    ogn_pkg::rsp_t want;
    cell_t         c;
    int            pick;
    int            k;
    bit            from_obj;
    pick     = $urandom_range(0, 99);
    r        = random_req(ogn_pkg::REQ_QUERY, cell_idx_t'($urandom), cell_idx_t'($urandom));
    k        = 0;
    from_obj = 1'b0;
    if (tracked_cells.size() != 0) begin
      k = $urandom_range(0, tracked_cells.size() - 1);
      c = tracked_cells[k];
    end
    if (pick < 25) begin
      r.req_type = ogn_pkg::REQ_ADD;
      if ($urandom_range(0, 2) == 0) begin
        r.cell_row = $urandom_range(0, 1) ? '1 : '0;
        r.cell_col = $urandom_range(0, 1) ? '1 : '0;
      end
    end else if (pick < 40) begin
      r.req_type = ogn_pkg::REQ_REMOVE;
      if (tracked_cells.size() != 0 && $urandom_range(0, 4) != 0) begin
        from_obj   = 1'b1;
        r.cell_row = c.row;
        r.cell_col = c.col;
      end
    end else if (pick < 62) begin
      r.req_type   = ogn_pkg::REQ_MOVE;
      r.update_map = ($urandom_range(0, 6) != 0);
      if (tracked_cells.size() != 0 && $urandom_range(0, 4) != 0) begin
        from_obj   = 1'b1;
        r.cell_row = c.row;
        r.cell_col = c.col;
      end
      if ($urandom_range(0, 4) < 3) begin
        r.world_x = world_for_cell(cell_idx_t'(r.cell_row + $urandom_range(0, 2) - 1));
        r.world_z = world_for_cell(cell_idx_t'(r.cell_col + $urandom_range(0, 2) - 1));
      end
    end else if (pick < 94) begin
      r.req_type = ogn_pkg::REQ_QUERY;
      r.radius   = ($urandom_range(0, 3) == 0) ? radius_t'($urandom_range(0, 7))
                                               : radius_t'($urandom_range(0, 2));
      if (tracked_cells.size() != 0 && $urandom_range(0, 2) == 0) begin
        r.cell_row = cell_idx_t'(c.row + $urandom_range(0, 4) - 2);
        r.cell_col = cell_idx_t'(c.col + $urandom_range(0, 4) - 2);
      end
    end else if (pick < 96) begin
      r.req_type = ogn_pkg::REQ_CLEAR;
    end else begin
      r.req_type = req_code_t'($urandom_range(REQ_UNDEF_FIRST, REQ_UNDEF_LAST));
    end
    send_request(r, want);
    // keep the object list in step with the grid
    case (r.req_type)
      ogn_pkg::REQ_ADD: begin
        if (tracked_cells.size() < TRACKED_MAX) tracked_cells.push_back({r.cell_row, r.cell_col});
      end
      ogn_pkg::REQ_REMOVE: begin
        if (from_obj) tracked_cells.delete(k);
      end
      ogn_pkg::REQ_MOVE: begin
        if (from_obj && r.update_map && grid_on) tracked_cells[k] = {want.new_row, want.new_col};
      end
      ogn_pkg::REQ_CLEAR: begin
        tracked_cells.delete();
      end
      default: ;
    endcase
  endtask

  // random phases, each with its own enable and idling mix
  task automatic test_random_phases();
    bit phase_enable [RANDOM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    int p;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      set_grid_enable(phase_enable[p]);
      tx_burst = (p == 3);
      rx_burst = (p == 4);
      repeat (PHASE_ITEMS) random_item();
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  task automatic note_failure(string what, ogn_pkg::rsp_t want, ogn_pkg::rsp_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t %s: expected culled=%0b row=%0d col=%0d, got culled=%0b row=%0d col=%0d",
               $time, what, want.culled, want.new_row, want.new_col,
               got.culled, got.new_row, got.new_col);
  endtask

  // response side: random stall before each beat
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_stall > 0) begin
        rsp_ready <= 1'b0;
        rx_stall--;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // compare each response beat with the oldest expected answer
  always @(posedge clk) begin : check_answers
    ogn_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      rx_stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (expected_answers.size() == 0) begin
        note_failure("response with nothing outstanding", '0, rsp);
      end else begin
        want = expected_answers.pop_front();
        if (rsp.culled !== want.culled || rsp.new_row !== want.new_row ||
            rsp.new_col !== want.new_col)
          note_failure("response mismatch", want, rsp);
      end
    end
  end

  // test sequence
  initial begin
    rst               = 1'b1;
    grid_enable_we    = 1'b0;
    grid_enable_wdata = 1'b0;
    req_valid         = 1'b0;
    req               = '0;
    mismatch_count    = 0;
    rx_stall          = 0;
    tx_burst          = 1'b0;
    rx_burst          = 1'b0;
    grid_on           = 1'b1;
    foreach (grid_counts[i]) grid_counts[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_corners_and_radius();
    test_remove_floor();
    test_move();
    test_saturation();
    test_disabled();
    test_undefined();
    test_random_phases();

    drain_grid();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_answers.size() == 0) begin
      $display("tb_occupancy_grid_neighbourhood_cull: clean");
    end else begin
      $display("tb_occupancy_grid_neighbourhood_cull: errors");
    end
    $finish;
  end

endmodule
